/* src/assert_macros.svh */
// assertion macros used by the port-level checker file
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, disabled while reset is asserted
`define CHK_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

// same, with a message of the caller's choice
`define CHK_ASSERT_MSG(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

`endif

/* src/x86alu_pkg.sv */
// types, codes and helpers of the x86 integer alu
// no dependencies; used by the top level and its checker
`default_nettype none

package x86alu_pkg;

  localparam int unsigned DataW = 32;

  // command codes
  typedef enum logic [3:0] {
    CMD_ADC  = 4'd0,
    CMD_ADD  = 4'd1,
    CMD_AND  = 4'd2,
    CMD_CMP  = 4'd3,
    CMD_OR   = 4'd4,
    CMD_SBB  = 4'd5,
    CMD_SUB  = 4'd6,
    CMD_TEST = 4'd7,
    CMD_XOR  = 4'd8
  } cmd_e;

  // operand size codes
  localparam logic [1:0] SIZE_8  = 2'd0;
  localparam logic [1:0] SIZE_16 = 2'd1;

  // flag bit positions in the flags word
  localparam int unsigned FlagCf = 0;
  localparam int unsigned FlagPf = 2;
  localparam int unsigned FlagAf = 4;
  localparam int unsigned FlagZf = 6;
  localparam int unsigned FlagSf = 7;
  localparam int unsigned FlagOf = 11;

  localparam logic [DataW-1:0] FLAG_MASK = 32'h0000_08D5;

  // operation class after decode
  typedef enum logic [2:0] {
    KIND_ADD = 3'd0,
    KIND_SUB = 3'd1,
    KIND_AND = 3'd2,
    KIND_OR  = 3'd3,
    KIND_XOR = 3'd4
  } kind_e;

  // decode stage contents
  typedef struct packed {
    logic [DataW-1:0] d;
    logic [DataW-1:0] s;
    logic [DataW-1:0] flags;
    logic [1:0]       size;
    kind_e            kind;
    logic             cin;
    logic             wb;
    logic             unknown;
  } dec_t;

  // execute stage contents
  typedef struct packed {
    logic [DataW-1:0] r;
    logic [DataW-1:0] d;
    logic [DataW-1:0] s;
    logic [DataW-1:0] flags;
    logic [1:0]       size;
    kind_e            kind;
    logic             carry;
    logic             wb;
    logic             unknown;
  } exe_t;

  function automatic logic [DataW-1:0] size_mask(input logic [1:0] size);
    logic [DataW-1:0] m;
    case (size)
      SIZE_8:  m = 32'h0000_00FF;
      SIZE_16: m = 32'h0000_FFFF;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

  function automatic logic sign_bit(input logic [DataW-1:0] v, input logic [1:0] size);
    logic b;
    case (size)
      SIZE_8:  b = v[7];
      SIZE_16: b = v[15];
      default: b = v[31];
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

/* src/x86_integer_alu_with_flags_top.sv */
// x86 integer alu with flags: three-stage pipeline, decode / add / flags
// depends on x86alu_pkg
`default_nettype none

// usage
// - a request is taken at every rising edge where start_i is high and busy_o
//   is low; busy_o is always low, so a request may be issued every cycle
// - a request carries command, operand size, destination, source, the
//   byte sign-extension select and the incoming flags word
// - done_o rises once the request has passed the decode, execute and flags
//   registers, and stays high for one cycle with result_value_o, write_back_o
//   and flags_out_o; the receiver takes them at the edge that ends that cycle
// - throughput is one request per cycle: stage one
//   masks and decodes operands, stage two holds the single 33-bit adder and
//   the logic ops, stage three forms carry, parity, zero, sign, af and of
// - cmp and test produce flags with write_back_o low; unknown commands give
//   a zero result, write_back_o low and the flags word passed unchanged
// - the receiver cannot stall, so nothing holds the pipeline; valid bits
//   move with the data every cycle
// - reset (async, active low) clears the stage valid bits; done_o stays low
//   until a request has passed through all three stages
module x86_integer_alu_with_flags_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [3:0]  command_i,
  input  wire logic [1:0]  size_select_i,
  input  wire logic [31:0] dest_value_i,
  input  wire logic [31:0] source_value_i,
  input  wire logic        imm_sign_extend_i,
  input  wire logic [31:0] flags_in_i,
  output logic             done_o,
  output logic [31:0]      result_value_o,
  output logic             write_back_o,
  output logic [31:0]      flags_out_o
);

  // stage valid bits
  logic v1_q, v2_q, v3_q;

  // stage payloads
  x86alu_pkg::dec_t dec_d, dec_q;
  x86alu_pkg::exe_t exe_d, exe_q;
  logic [31:0] res_d, res_q;
  logic        wb_d, wb_q;
  logic [31:0] flg_d, flg_q;

  logic accept;

  // no back pressure anywhere in the pipe
  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  // ---------------- stage 1: operand masking and decode ----------------
  logic [31:0] mask1;
  logic [31:0] src_ext;

  always_comb begin
    mask1   = x86alu_pkg::size_mask(size_select_i);
    // 8-bit immediate sign extended before truncation to operand width
    src_ext = imm_sign_extend_i ? {{24{source_value_i[7]}}, source_value_i[7:0]}
                                : source_value_i;
    dec_d         = '0;
    dec_d.d       = dest_value_i & mask1;
    dec_d.s       = src_ext & mask1;
    dec_d.flags   = flags_in_i;
    dec_d.size    = size_select_i;
    dec_d.wb      = 1'b1;
    dec_d.unknown = 1'b0;
    dec_d.kind    = x86alu_pkg::KIND_ADD;
    dec_d.cin     = 1'b0;
    case (command_i)
      x86alu_pkg::CMD_ADC: begin
        dec_d.cin = flags_in_i[x86alu_pkg::FlagCf];
      end
      x86alu_pkg::CMD_ADD: begin
        dec_d.cin = 1'b0;
      end
      x86alu_pkg::CMD_AND: begin
        dec_d.kind = x86alu_pkg::KIND_AND;
      end
      x86alu_pkg::CMD_CMP: begin
        // subtract as d + ~s + 1
        dec_d.kind = x86alu_pkg::KIND_SUB;
        dec_d.cin  = 1'b1;
        dec_d.wb   = 1'b0;
      end
      x86alu_pkg::CMD_OR: begin
        dec_d.kind = x86alu_pkg::KIND_OR;
      end
      x86alu_pkg::CMD_SBB: begin
        // borrow in folds into the adder carry in
        dec_d.kind = x86alu_pkg::KIND_SUB;
        dec_d.cin  = ~flags_in_i[x86alu_pkg::FlagCf];
      end
      x86alu_pkg::CMD_SUB: begin
        dec_d.kind = x86alu_pkg::KIND_SUB;
        dec_d.cin  = 1'b1;
      end
      x86alu_pkg::CMD_TEST: begin
        dec_d.kind = x86alu_pkg::KIND_AND;
        dec_d.wb   = 1'b0;
      end
      x86alu_pkg::CMD_XOR: begin
        dec_d.kind = x86alu_pkg::KIND_XOR;
      end
      default: begin
        dec_d.unknown = 1'b1;
        dec_d.wb      = 1'b0;
      end
    endcase
  end

  // ---------------- stage 2: adder and logic ops ----------------
  logic [31:0] mask2;
  logic [31:0] addend;
  logic [32:0] sum;

  always_comb begin
    mask2  = x86alu_pkg::size_mask(dec_q.size);
    addend = (dec_q.kind == x86alu_pkg::KIND_SUB) ? (~dec_q.s & mask2) : dec_q.s;
    sum    = {1'b0, dec_q.d} + {1'b0, addend} + {32'd0, dec_q.cin};

    exe_d         = '0;
    exe_d.d       = dec_q.d;
    exe_d.s       = dec_q.s;
    exe_d.flags   = dec_q.flags;
    exe_d.size    = dec_q.size;
    exe_d.kind    = dec_q.kind;
    exe_d.wb      = dec_q.wb;
    exe_d.unknown = dec_q.unknown;

    // carry out of the operand width; operands are masked so only it lands there
    case (dec_q.size)
      x86alu_pkg::SIZE_8:  exe_d.carry = sum[8];
      x86alu_pkg::SIZE_16: exe_d.carry = sum[16];
      default:             exe_d.carry = sum[32];
    endcase

    case (dec_q.kind)
      x86alu_pkg::KIND_ADD,
      x86alu_pkg::KIND_SUB: exe_d.r = sum[31:0] & mask2;
      x86alu_pkg::KIND_AND: exe_d.r = dec_q.d & dec_q.s;
      x86alu_pkg::KIND_OR:  exe_d.r = dec_q.d | dec_q.s;
      x86alu_pkg::KIND_XOR: exe_d.r = dec_q.d ^ dec_q.s;
      default:              exe_d.r = '0;
    endcase
  end

  // ---------------- stage 3: flag generation ----------------
  logic is_add, is_sub;
  logic cf, pf, af, zf, sf, of;

  always_comb begin
    is_add = (exe_q.kind == x86alu_pkg::KIND_ADD);
    is_sub = (exe_q.kind == x86alu_pkg::KIND_SUB);
    // adder carry is the inverted borrow for subtracts
    cf = (is_add & exe_q.carry) | (is_sub & ~exe_q.carry);
    af = (is_add | is_sub) & (exe_q.d[4] ^ exe_q.s[4] ^ exe_q.r[4]);
    of = (is_add & x86alu_pkg::sign_bit(~(exe_q.d ^ exe_q.s) & (exe_q.d ^ exe_q.r),
                                        exe_q.size))
       | (is_sub & x86alu_pkg::sign_bit((exe_q.d ^ exe_q.s) & (exe_q.d ^ exe_q.r),
                                        exe_q.size));
    pf = ~(^exe_q.r[7:0]);
    zf = (exe_q.r == '0);
    sf = x86alu_pkg::sign_bit(exe_q.r, exe_q.size);

    flg_d = exe_q.flags & ~x86alu_pkg::FLAG_MASK;
    flg_d[x86alu_pkg::FlagCf] = cf;
    flg_d[x86alu_pkg::FlagPf] = pf;
    flg_d[x86alu_pkg::FlagAf] = af;
    flg_d[x86alu_pkg::FlagZf] = zf;
    flg_d[x86alu_pkg::FlagSf] = sf;
    flg_d[x86alu_pkg::FlagOf] = of;
    res_d = exe_q.r;
    wb_d  = exe_q.wb;

    // unknown command: zero result, flags untouched
    if (exe_q.unknown) begin
      flg_d = exe_q.flags;
      res_d = '0;
      wb_d  = 1'b0;
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // payload registers, loaded only with a valid request
  always_ff @(posedge clk_i) begin
    if (accept) begin
      dec_q <= dec_d;
    end
    if (v1_q) begin
      exe_q <= exe_d;
    end
    if (v2_q) begin
      res_q <= res_d;
      wb_q  <= wb_d;
      flg_q <= flg_d;
    end
  end

  assign done_o         = v3_q;
  assign result_value_o = res_q;
  assign write_back_o   = wb_q;
  assign flags_out_o    = flg_q;

endmodule

`default_nettype wire

/* src/x86alu_chk.sv */
// port-level checker for the x86 integer alu, bound to the top level
// depends on x86alu_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module x86alu_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start_i,
  input wire logic        busy_o,
  input wire logic [3:0]  command_i,
  input wire logic [31:0] flags_in_i,
  input wire logic        done_o,
  input wire logic        write_back_o,
  input wire logic [31:0] flags_out_o
);

  logic req;
  logic cmd_logic;
  logic cmd_wb;

  assign req       = start_i & ~busy_o;
  assign cmd_logic = (command_i == x86alu_pkg::CMD_AND) || (command_i == x86alu_pkg::CMD_OR)
                  || (command_i == x86alu_pkg::CMD_TEST) || (command_i == x86alu_pkg::CMD_XOR);
  assign cmd_wb    = (command_i <= x86alu_pkg::CMD_XOR) && (command_i != x86alu_pkg::CMD_CMP)
                  && (command_i != x86alu_pkg::CMD_TEST);

  // each request gives exactly one strobe, after the decode, execute and flags registers
  `CHK_ASSERT_MSG(a_done_latency, clk_i, rst_ni, done_o == $past(req, 3), "strobe mismatch")

  // write back follows the command of the request
  `CHK_ASSERT(a_write_back, clk_i, rst_ni, done_o |-> write_back_o == $past(cmd_wb, 3))

  // bits outside the arithmetic flags pass through untouched
  `CHK_ASSERT(a_flags_keep, clk_i, rst_ni,
    done_o |-> ((flags_out_o & ~x86alu_pkg::FLAG_MASK) ==
                ($past(flags_in_i, 3) & ~x86alu_pkg::FLAG_MASK)))

  // logic operations clear cf, af and of
  `CHK_ASSERT(a_logic_clear, clk_i, rst_ni,
    (done_o && $past(cmd_logic, 3)) |->
      (!flags_out_o[x86alu_pkg::FlagCf] && !flags_out_o[x86alu_pkg::FlagAf]
       && !flags_out_o[x86alu_pkg::FlagOf]))

endmodule

bind x86_integer_alu_with_flags_top x86alu_chk u_x86alu_chk (.*);

`default_nettype wire

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// self-checking testbench of the x86 integer alu with flags
// holds its own alu and flags predictor; depends on x86alu_pkg and the top level
module testbench;

  // size codes the package leaves unnamed: two is 32 bits, three falls back to 32 bits
  localparam logic [1:0] SIZE_32   = 2'd2;
  localparam logic [1:0] SIZE_WIDE = 2'd3;

  // command codes past the last operation are ignored by the block
  localparam logic [3:0] CMD_UNKNOWN_LO = 4'd9;
  localparam logic [3:0] CMD_UNKNOWN_HI = 4'd15;

  // cycles with neither a request nor a result before the run is declared hung
  localparam int unsigned STALL_LIMIT = 200;
  // cycles waited after the last result, well past the three-stage pipeline
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned RANDOM_PER_PHASE = 450;

  typedef struct packed {
    logic [3:0]  command;
    logic [1:0]  size;
    logic [31:0] dest;
    logic [31:0] source;
    logic        sign_ext;
    logic [31:0] flags;
  } alu_req_t;

  typedef struct packed {
    logic [31:0] value;
    logic        write_back;
    logic [31:0] flags;
  } alu_res_t;

  // a request waiting for the driver, with the chance in percent of an idle
  // cycle before it goes out
  typedef struct {
    alu_req_t    req;
    int unsigned gap_pct;
  } queued_req_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic        done_o;
  logic [31:0] result_value_o;
  logic        write_back_o;
  logic [31:0] flags_out_o;

  // request currently on the input ports
  alu_req_t    drv_req = '0;
  logic        req_taken = 1'b0;

  queued_req_t queued_reqs[$];
  alu_res_t    awaited_results[$];
  alu_res_t    oldest;
  int unsigned mismatches = 0;
  int unsigned stall_cycles = 0;

  x86_integer_alu_with_flags_top u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .command_i        (drv_req.command),
    .size_select_i    (drv_req.size),
    .dest_value_i     (drv_req.dest),
    .source_value_i   (drv_req.source),
    .imm_sign_extend_i(drv_req.sign_ext),
    .flags_in_i       (drv_req.flags),
    .done_o           (done_o),
    .result_value_o   (result_value_o),
    .write_back_o     (write_back_o),
    .flags_out_o      (flags_out_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // x86 semantics of one request: operands cut to the width, optional byte
  // sign extension of the source, six status flags replaced in the flags word
  function automatic alu_res_t compute_alu_result(input alu_req_t rq);
    logic [31:0] width_mask;
    logic [31:0] sign_mask;
    logic [31:0] d;
    logic [31:0] s;
    logic [31:0] r;
    logic [31:0] half_carry;
    logic [32:0] wide;
    logic [32:0] subtrahend;
    logic        carry_in;
    logic        cf;
    logic        af;
    logic        of;
    alu_res_t    res;

    // unknown command: nothing computed, flags word passed through
    if (rq.command > x86alu_pkg::CMD_XOR) begin
      res.value = '0;
      res.write_back = 1'b0;
      res.flags = rq.flags;
      return res;
    end

    case (rq.size)
      x86alu_pkg::SIZE_8: begin
        width_mask = 32'h0000_00FF;
        sign_mask  = 32'h0000_0080;
      end
      x86alu_pkg::SIZE_16: begin
        width_mask = 32'h0000_FFFF;
        sign_mask  = 32'h0000_8000;
      end
      default: begin
        width_mask = 32'hFFFF_FFFF;
        sign_mask  = 32'h8000_0000;
      end
    endcase

    s = rq.source;
    if (rq.sign_ext) begin
      s = {{24{s[7]}}, s[7:0]};
    end
    d = rq.dest & width_mask;
    s = s & width_mask;
    carry_in = rq.flags[x86alu_pkg::FlagCf];
    cf = 1'b0;
    af = 1'b0;
    of = 1'b0;

    case (x86alu_pkg::cmd_e'(rq.command))
      x86alu_pkg::CMD_ADC, x86alu_pkg::CMD_ADD: begin
        wide = {1'b0, d} + {1'b0, s}
             + {32'd0, (rq.command == x86alu_pkg::CMD_ADC) & carry_in};
        r = wide[31:0] & width_mask;
        cf = wide > {1'b0, width_mask};
        half_carry = d ^ s ^ r;
        af = half_carry[4];
        of = |(~(d ^ s) & (d ^ r) & sign_mask);
      end
      x86alu_pkg::CMD_CMP, x86alu_pkg::CMD_SBB, x86alu_pkg::CMD_SUB: begin
        // borrow in only for sbb
        subtrahend = {1'b0, s} + {32'd0, (rq.command == x86alu_pkg::CMD_SBB) & carry_in};
        wide = {1'b0, d} - subtrahend;
        r = wide[31:0] & width_mask;
        cf = {1'b0, d} < subtrahend;
        half_carry = d ^ s ^ r;
        af = half_carry[4];
        of = |((d ^ s) & (d ^ r) & sign_mask);
      end
      x86alu_pkg::CMD_AND, x86alu_pkg::CMD_TEST: r = d & s;
      x86alu_pkg::CMD_OR:                        r = d | s;
      default:                                   r = d ^ s;
    endcase

    res.value = r;
    res.write_back = !(rq.command == x86alu_pkg::CMD_CMP ||
                       rq.command == x86alu_pkg::CMD_TEST);
    res.flags = rq.flags & ~x86alu_pkg::FLAG_MASK;
    res.flags[x86alu_pkg::FlagCf] = cf;
    res.flags[x86alu_pkg::FlagPf] = ~^r[7:0];
    res.flags[x86alu_pkg::FlagAf] = af;
    res.flags[x86alu_pkg::FlagZf] = (r == 32'd0);
    res.flags[x86alu_pkg::FlagSf] = |(r & sign_mask);
    res.flags[x86alu_pkg::FlagOf] = of;
    return res;
  endfunction

  task automatic add_req(input logic [3:0] cmd, input logic [1:0] size,
                         input logic [31:0] d, input logic [31:0] s, input logic sx,
                         input logic [31:0] flags, input int unsigned gap_pct);
    queued_req_t item;
    item.req = '{command: cmd, size: size, dest: d, source: s, sign_ext: sx, flags: flags};
    item.gap_pct = gap_pct;
    queued_reqs.push_back(item);
  endtask

  // operands biased toward the values where carry, sign and overflow turn over
  function automatic logic [31:0] pick_operand();
    logic [31:0] v;
    case ($urandom_range(7))
      0:       v = 32'd0;
      1:       v = 32'hFFFF_FFFF;
      2:       v = 32'h0000_0080 << (8 * $urandom_range(3));
      3:       v = 32'h0000_007F << (8 * $urandom_range(3)) | ($urandom_range(1) ? 32'hFF : 32'h0);
      4:       v = $urandom_range(31);
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic add_random_req(input int unsigned gap_pct);
    logic [3:0]  cmd;
    logic [1:0]  size;
    logic [31:0] d;
    logic [31:0] s;
    if ($urandom_range(19) == 0) begin
      cmd = 4'($urandom_range(CMD_UNKNOWN_HI, CMD_UNKNOWN_LO));
    end else begin
      cmd = 4'($urandom_range(x86alu_pkg::CMD_XOR, x86alu_pkg::CMD_ADC));
    end
    if ($urandom_range(15) == 0) begin
      size = SIZE_WIDE;
    end else begin
      size = 2'($urandom_range(SIZE_32, x86alu_pkg::SIZE_8));
    end
    d = pick_operand();
    // equal and negated pairs give zero results and borrow edges
    case ($urandom_range(7))
      0:       s = d;
      1:       s = -d;
      default: s = pick_operand();
    endcase
    add_req(cmd, size, d, s, $urandom_range(3) == 0, $urandom, gap_pct);
  endtask

  task automatic check_field(input string label, input logic [31:0] exp_val,
                             input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, label, exp_val, act_val);
      mismatches++;
    end
  endtask

  // driver: a new request goes out at the falling edge once the previous one
  // was taken; the idle chance of the head request leaves random gaps
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else if (start_i && !req_taken) begin
      // hold the request until the block takes it
    end else if (queued_reqs.size() != 0 &&
                 $urandom_range(99) >= queued_reqs[0].gap_pct) begin
      drv_req <= queued_reqs[0].req;
      void'(queued_reqs.pop_front());
      start_i <= 1'b1;
    end else begin
      start_i <= 1'b0;
    end
  end

  // monitor: results are checked against the oldest prediction first, then a
  // request taken at this edge gets its prediction queued
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: result with nothing awaited, actual value %h flags %h",
                   $time, result_value_o, flags_out_o);
          mismatches++;
        end else begin
          oldest = awaited_results.pop_front();
          check_field("result_value", oldest.value, result_value_o);
          check_field("write_back", {31'd0, oldest.write_back}, {31'd0, write_back_o});
          check_field("flags_out", oldest.flags, flags_out_o);
        end
      end
      if (start_i && !busy_o) begin
        awaited_results.push_back(compute_alu_result(drv_req));
      end
    end
    req_taken <= start_i && !busy_o;
  end

  // watchdog: counts cycles in which neither a request nor a result moves
  always @(posedge clk_i) begin
    if (!rst_ni || done_o || (start_i && !busy_o)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int unsigned gap_pcts[4];
    gap_pcts = '{0, 50, 29, 0};

    // directed part: carries, borrows, overflows, zero results, half carry,
    // flags word with every bit set, sign extension at each width, the
    // fallback size and ignored commands
    add_req(x86alu_pkg::CMD_ADD, SIZE_32,
            32'hFFFF_FFFF, 32'h0000_0001, 1'b0, 32'h0000_0000, 0);
    add_req(x86alu_pkg::CMD_ADC, SIZE_32,
            32'h7FFF_FFFF, 32'h0000_0000, 1'b0, 32'h0000_0001, 0);
    add_req(x86alu_pkg::CMD_ADC, x86alu_pkg::SIZE_16,
            32'hABCD_FFFF, 32'h1234_FFFF, 1'b0, 32'hFFFF_FFFF, 0);
    add_req(x86alu_pkg::CMD_ADD, x86alu_pkg::SIZE_8,
            32'hFFFF_FF0F, 32'hFFFF_FF01, 1'b0, 32'h0000_0000, 0);
    add_req(x86alu_pkg::CMD_SUB, SIZE_32,
            32'h0000_0000, 32'h0000_0001, 1'b0, 32'h0000_0000, 0);
    add_req(x86alu_pkg::CMD_SUB, x86alu_pkg::SIZE_8,
            32'h0000_0080, 32'h0000_0001, 1'b0, 32'hFFFF_FFFF, 0);
    add_req(x86alu_pkg::CMD_SBB, SIZE_32,
            32'h8000_0000, 32'h0000_0000, 1'b0, 32'h0000_0001, 0);
    add_req(x86alu_pkg::CMD_SBB, x86alu_pkg::SIZE_16,
            32'h0000_0000, 32'h0000_FFFF, 1'b0, 32'h0000_0001, 0);
    add_req(x86alu_pkg::CMD_CMP, SIZE_32,
            32'h1234_5678, 32'h1234_5678, 1'b0, 32'h0000_0000, 0);
    add_req(x86alu_pkg::CMD_CMP, x86alu_pkg::SIZE_16,
            32'h0000_7FFF, 32'h0000_8000, 1'b0, 32'hFFFF_FFFF, 0);
    add_req(x86alu_pkg::CMD_AND, SIZE_32,
            32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 0);
    add_req(x86alu_pkg::CMD_OR, SIZE_32,
            32'h0000_0000, 32'h0000_0000, 1'b0, 32'hFFFF_FFFF, 0);
    add_req(x86alu_pkg::CMD_TEST, x86alu_pkg::SIZE_8,
            32'hFFFF_FF80, 32'h0000_00FF, 1'b0, 32'h0000_0000, 0);
    add_req(x86alu_pkg::CMD_XOR, x86alu_pkg::SIZE_16,
            32'h0000_A5A5, 32'h0000_A5A5, 1'b0, 32'h0000_0000, 0);
    add_req(x86alu_pkg::CMD_ADD, x86alu_pkg::SIZE_16,
            32'h0000_0001, 32'h0000_0080, 1'b1, 32'h0000_0000, 0);
    add_req(x86alu_pkg::CMD_ADD, SIZE_32,
            32'h0000_0000, 32'h1234_5680, 1'b1, 32'h0000_0000, 0);
    add_req(x86alu_pkg::CMD_SUB, x86alu_pkg::SIZE_8,
            32'h0000_0010, 32'h0000_0090, 1'b1, 32'h0000_0000, 0);
    add_req(x86alu_pkg::CMD_AND, SIZE_32,
            32'h0F0F_0F0F, 32'hFFFF_FF7F, 1'b1, 32'h0000_0000, 0);
    add_req(x86alu_pkg::CMD_ADD, SIZE_WIDE,
            32'h8000_0000, 32'h8000_0000, 1'b0, 32'h0000_0000, 0);
    add_req(CMD_UNKNOWN_LO, SIZE_32,
            32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hDEAD_BEEF, 0);
    add_req(CMD_UNKNOWN_HI, x86alu_pkg::SIZE_8,
            32'h0000_0001, 32'h0000_0001, 1'b0, 32'hFFFF_FFFF, 0);

    // random part in phases of sender idling, some of them without idling
    foreach (gap_pcts[p]) begin
      repeat (RANDOM_PER_PHASE) add_random_req(gap_pcts[p]);
    end

    // reset held from the start, released at a falling edge, away from the rising edge
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (queued_reqs.size() != 0 || start_i) @(posedge clk_i);
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
